// ----- rtl/core/bpe_pkg.sv -----
// Shared constants, tables and types for the battery percent estimator.
// Holds the LiPo curve, the per-segment divisor tables and the stage payload structs.
// No dependencies; every other file in rtl/core imports this package.
package bpe_pkg;

    localparam int ADC_BITS        = 12;
    localparam int CURVE_POINTS    = 13;
    localparam int FULL_SCALE      = (1 << ADC_BITS) - 1;

    localparam int SPAN_MV         = 6600;
    localparam int NOMINAL_FULL_MV = 3900;
    localparam int CLAMP_LO_MV     = 3000;
    localparam int CLAMP_HI_MV     = 4200;
    localparam int CHARGING_PCT    = 100;

    localparam int MV_W   = 13;
    localparam int PCT_W  = 8;
    localparam int RAW_W  = ADC_BITS + 13;
    localparam int V_W    = ADC_BITS + 15;
    localparam int D_W    = ADC_BITS + 11;
    localparam int N_W    = ADC_BITS + 12;
    localparam int DEN_W  = ADC_BITS + 8;
    localparam int DP_W   = 4;
    localparam int RCP_W  = 9;
    localparam int Q_W    = 7;

    // Segments 0 .. CURVE_POINTS-2 are the LiPo curve; the last code is the linear map.
    localparam int NUM_SEGS   = CURVE_POINTS;
    localparam int LINEAR_SEG = CURVE_POINTS - 1;
    localparam int SEG_W      = $clog2(NUM_SEGS);
    localparam int LINEAR_DMV = (CLAMP_HI_MV - CLAMP_LO_MV) / 100;

    localparam int DIV_SHIFT = N_W;
    localparam int DIV_ONE   = 1 << DIV_SHIFT;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 13;

    localparam logic [CFG_IDX_W-1:0] REG_BATTERY_MODEL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHARGE_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_BATTERY     = 2'd2;

    localparam logic MODEL_LIPO   = 1'b0;
    localparam logic MODEL_LINEAR = 1'b1;

    localparam int CURVE_MV [CURVE_POINTS] = '{
        3900, 3800, 3720, 3650, 3590, 3530, 3480,
        3440, 3400, 3360, 3300, 3150, 3000
    };
    localparam int CURVE_PCT [CURVE_POINTS] = '{
        100, 90, 80, 70, 60, 50, 40, 30, 20, 15, 10, 5, 0
    };

    // Reciprocals of the segment divisors, scaled by 2^DIV_SHIFT and rounded down.
    localparam int SEG_RECIP [NUM_SEGS] = '{
        DIV_ONE / ((CURVE_MV[0]  - CURVE_MV[1])  * FULL_SCALE),
        DIV_ONE / ((CURVE_MV[1]  - CURVE_MV[2])  * FULL_SCALE),
        DIV_ONE / ((CURVE_MV[2]  - CURVE_MV[3])  * FULL_SCALE),
        DIV_ONE / ((CURVE_MV[3]  - CURVE_MV[4])  * FULL_SCALE),
        DIV_ONE / ((CURVE_MV[4]  - CURVE_MV[5])  * FULL_SCALE),
        DIV_ONE / ((CURVE_MV[5]  - CURVE_MV[6])  * FULL_SCALE),
        DIV_ONE / ((CURVE_MV[6]  - CURVE_MV[7])  * FULL_SCALE),
        DIV_ONE / ((CURVE_MV[7]  - CURVE_MV[8])  * FULL_SCALE),
        DIV_ONE / ((CURVE_MV[8]  - CURVE_MV[9])  * FULL_SCALE),
        DIV_ONE / ((CURVE_MV[9]  - CURVE_MV[10]) * FULL_SCALE),
        DIV_ONE / ((CURVE_MV[10] - CURVE_MV[11]) * FULL_SCALE),
        DIV_ONE / ((CURVE_MV[11] - CURVE_MV[12]) * FULL_SCALE),
        DIV_ONE / (LINEAR_DMV * FULL_SCALE)
    };

    typedef struct packed {
        logic             battery_model;
        logic [MV_W-1:0]  charge_threshold_mv;
        logic [MV_W-1:0]  full_battery_mv;
    } cfg_t;

    // Clamped voltage, expressed as the excess over the lower clamp in 1/FULL_SCALE mV.
    typedef struct packed {
        logic             charging;
        logic             linear;
        logic [D_W-1:0]   excess;
    } clamp_t;

    typedef struct packed {
        logic             charging;
        logic [SEG_W-1:0] seg;
        logic [N_W-1:0]   numer;
    } numer_t;

    // Lower end of a segment, relative to the lower clamp.
    function automatic logic [D_W-1:0] seg_lo(input logic [SEG_W-1:0] s);
        int lo;
        begin
            lo = 0;
            if (int'(s) < LINEAR_SEG)
            begin
                lo = (CURVE_MV[int'(s) + 1] - CLAMP_LO_MV) * FULL_SCALE;
            end
            return D_W'(lo);
        end
    endfunction

    function automatic logic [DEN_W-1:0] seg_den(input logic [SEG_W-1:0] s);
        int den;
        begin
            den = LINEAR_DMV * FULL_SCALE;
            if (int'(s) < LINEAR_SEG)
            begin
                den = (CURVE_MV[int'(s)] - CURVE_MV[int'(s) + 1]) * FULL_SCALE;
            end
            return DEN_W'(den);
        end
    endfunction

    function automatic logic [DP_W-1:0] seg_dp(input logic [SEG_W-1:0] s);
        int dp;
        begin
            dp = 1;
            if (int'(s) < LINEAR_SEG)
            begin
                dp = CURVE_PCT[int'(s)] - CURVE_PCT[int'(s) + 1];
            end
            return DP_W'(dp);
        end
    endfunction

    function automatic logic [PCT_W-1:0] seg_base(input logic [SEG_W-1:0] s);
        int base;
        begin
            base = 0;
            if (int'(s) < LINEAR_SEG)
            begin
                base = CURVE_PCT[int'(s) + 1];
            end
            return PCT_W'(base);
        end
    endfunction

    function automatic logic [RCP_W-1:0] seg_recip(input logic [SEG_W-1:0] s);
        int rcp;
        begin
            rcp = SEG_RECIP[LINEAR_SEG];
            if (int'(s) < LINEAR_SEG)
            begin
                rcp = SEG_RECIP[int'(s)];
            end
            return RCP_W'(rcp);
        end
    endfunction

endpackage

// ----- rtl/core/bpe_front.sv -----
// Front stages: ADC scaling, charge detection, load offset and clamp.
// Two register stages with valid/ready; depends on bpe_pkg.
module bpe_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bpe_pkg::cfg_t                  cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [bpe_pkg::ADC_BITS-1:0]   in_sample,
    output logic                           out_valid,
    input  logic                           out_ready,
    output bpe_pkg::clamp_t                out_data
);
    import bpe_pkg::*;

    localparam logic signed [V_W-1:0] LO_FS = V_W'(CLAMP_LO_MV * FULL_SCALE);
    localparam logic signed [V_W-1:0] HI_FS = V_W'(CLAMP_HI_MV * FULL_SCALE);
    localparam logic [D_W-1:0] TOP_EXCESS =
        D_W'((CLAMP_HI_MV - CLAMP_LO_MV) * FULL_SCALE);

    logic                     a_valid_reg;
    logic                     b_valid_reg;
    logic                     a_ready;
    logic                     b_ready;
    logic [RAW_W-1:0]         raw_reg;
    logic [RAW_W-1:0]         raw_next;
    clamp_t                   clamp_reg;
    clamp_t                   clamp_next;
    logic [RAW_W-1:0]         thr_fs;
    logic signed [MV_W:0]     offset_mv;
    logic signed [V_W-1:0]    offset_ext;
    logic signed [V_W-1:0]    offset_fs;
    logic signed [V_W-1:0]    volt;
    logic signed [V_W-1:0]    volt_rel;

    assign a_ready  = !a_valid_reg || b_ready;
    assign b_ready  = !b_valid_reg || out_ready;
    assign in_ready = a_ready;

    assign raw_next = {{(RAW_W-ADC_BITS){1'b0}}, in_sample} * RAW_W'(SPAN_MV);

    always_comb
    begin
        // x * FULL_SCALE is x * 2^ADC_BITS - x.
        thr_fs     = {cfg.charge_threshold_mv, {ADC_BITS{1'b0}}}
                   - {{ADC_BITS{1'b0}}, cfg.charge_threshold_mv};
        offset_mv  = $signed({1'b0, MV_W'(NOMINAL_FULL_MV)})
                   - $signed({1'b0, cfg.full_battery_mv});
        offset_ext = V_W'(offset_mv);
        offset_fs  = (offset_ext <<< ADC_BITS) - offset_ext;
        volt       = $signed({{(V_W-RAW_W){1'b0}}, raw_reg}) + offset_fs;
        volt_rel   = volt - LO_FS;

        clamp_next.charging = (raw_reg >= thr_fs);
        clamp_next.linear   = (cfg.battery_model == MODEL_LINEAR);
        if (volt < LO_FS)
        begin
            clamp_next.excess = '0;
        end
        else if (volt > HI_FS)
        begin
            clamp_next.excess = TOP_EXCESS;
        end
        else
        begin
            clamp_next.excess = volt_rel[D_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            raw_reg <= raw_next;
        end
        if (b_ready && a_valid_reg)
        begin
            clamp_reg <= clamp_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = clamp_reg;

endmodule

// ----- rtl/core/bpe_seg.sv -----
// Segment stages: picks the curve segment and forms the interpolation numerator.
// Two register stages with valid/ready; depends on bpe_pkg.
module bpe_seg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bpe_pkg::clamp_t   in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output bpe_pkg::numer_t   out_data
);
    import bpe_pkg::*;

    logic              c_valid_reg;
    logic              d_valid_reg;
    logic              c_ready;
    logic              d_ready;
    logic              c_charging_reg;
    logic [SEG_W-1:0]  c_seg_reg;
    logic [D_W-1:0]    c_delta_reg;
    logic [SEG_W-1:0]  seg_next;
    logic [D_W-1:0]    delta_next;
    numer_t            numer_reg;
    numer_t            numer_next;

    assign c_ready  = !c_valid_reg || d_ready;
    assign d_ready  = !d_valid_reg || out_ready;
    assign in_ready = c_ready;

    // The first segment whose lower end lies at or below the voltage wins.
    always_comb
    begin
        seg_next = SEG_W'(LINEAR_SEG - 1);
        for (int i = LINEAR_SEG - 2; i >= 0; i--)
        begin
            if (in_data.excess >= seg_lo(SEG_W'(i)))
            begin
                seg_next = SEG_W'(i);
            end
        end
        if (in_data.linear)
        begin
            seg_next = SEG_W'(LINEAR_SEG);
        end
        delta_next = in_data.excess - seg_lo(seg_next);
    end

    always_comb
    begin
        numer_next.charging = c_charging_reg;
        numer_next.seg      = c_seg_reg;
        numer_next.numer    = {{(N_W-D_W){1'b0}}, c_delta_reg}
                            * {{(N_W-DP_W){1'b0}}, seg_dp(c_seg_reg)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (c_ready)
            begin
                c_valid_reg <= in_valid;
            end
            if (d_ready)
            begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ready && in_valid)
        begin
            c_charging_reg <= in_data.charging;
            c_seg_reg      <= seg_next;
            c_delta_reg    <= delta_next;
        end
        if (d_ready && c_valid_reg)
        begin
            numer_reg <= numer_next;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_data  = numer_reg;

endmodule

// ----- rtl/core/bpe_div.sv -----
// Divide stages: quotient by reciprocal multiply, one-step correction, final percent.
// Two register stages with valid/ready; the second is the block's output register.
// Depends on bpe_pkg.
module bpe_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  bpe_pkg::numer_t             in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [bpe_pkg::PCT_W-1:0]   percent,
    output logic                        charging
);
    import bpe_pkg::*;

    localparam int PROD_W = N_W + RCP_W;
    localparam int STEP_W = Q_W + DEN_W + 1;

    logic                 e_valid_reg;
    logic                 f_valid_reg;
    logic                 e_ready;
    logic                 f_ready;
    numer_t               e_numer_reg;
    logic [Q_W-1:0]       e_quot_reg;
    logic [PROD_W-1:0]    prod;
    logic [Q_W-1:0]       quot_next;
    logic [DEN_W-1:0]     den;
    logic [STEP_W-1:0]    q_times_den;
    logic [STEP_W-1:0]    next_step;
    logic [Q_W-1:0]       quot_fixed;
    logic [PCT_W-1:0]     percent_next;
    logic [PCT_W-1:0]     percent_reg;
    logic                 charging_reg;

    assign e_ready  = !e_valid_reg || f_ready;
    assign f_ready  = !f_valid_reg || out_ready;
    assign in_ready = e_ready;

    // The estimate is the true quotient or one below it.
    assign prod      = {{RCP_W{1'b0}}, in_data.numer}
                     * {{N_W{1'b0}}, seg_recip(in_data.seg)};
    assign quot_next = prod[DIV_SHIFT +: Q_W];

    always_comb
    begin
        den          = seg_den(e_numer_reg.seg);
        q_times_den  = {{(DEN_W+1){1'b0}}, e_quot_reg} * {{(Q_W+1){1'b0}}, den};
        next_step    = q_times_den + {{(Q_W+1){1'b0}}, den};
        quot_fixed   = e_quot_reg;
        if ({{(STEP_W-N_W){1'b0}}, e_numer_reg.numer} >= next_step)
        begin
            quot_fixed = e_quot_reg + Q_W'(1);
        end
        if (e_numer_reg.charging)
        begin
            percent_next = PCT_W'(CHARGING_PCT);
        end
        else
        begin
            percent_next = seg_base(e_numer_reg.seg) + {{(PCT_W-Q_W){1'b0}}, quot_fixed};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else
        begin
            if (e_ready)
            begin
                e_valid_reg <= in_valid;
            end
            if (f_ready)
            begin
                f_valid_reg <= e_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_ready && in_valid)
        begin
            e_numer_reg <= in_data;
            e_quot_reg  <= quot_next;
        end
        if (f_ready && e_valid_reg)
        begin
            percent_reg  <= percent_next;
            charging_reg <= e_numer_reg.charging;
        end
    end

    assign out_valid = f_valid_reg;
    assign percent   = percent_reg;
    assign charging  = charging_reg;

endmodule

// ----- rtl/core/battery_percent_estimator.sv -----
// Top level of the battery percent estimator: configuration registers and the pipeline.
// Instantiates bpe_front, bpe_seg and bpe_div; depends on bpe_pkg.
//
// The block turns one battery ADC sample into a state-of-charge estimate. It accepts one
// sample per cycle unless a stall from out_ready has backed up to the input, and returns
// one result per sample, in order: two stages scale the sample and clamp it, two pick the
// curve segment and form the numerator, and two divide by the segment width and form the
// percentage. Each stage holds its own valid bit and takes a new transaction whenever it
// is empty or its neighbor downstream moves, so empty slots close up and a low out_ready
// stalls only as far back as the pipeline is full. A sample at or above the charge
// threshold reports charging with 100 percent. Otherwise the load offset is added, the
// voltage is clamped to 3.0 to 4.2 V, and the percentage comes either from a linear map or
// from the 13-point LiPo curve, truncated; above 3.9 V the top curve segment is extended,
// so the LiPo result can reach 130. Configuration writes are always accepted and apply to
// each sample that enters the second front stage after the write; they are meant to be
// made while no sample is in flight.
module battery_percent_estimator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bpe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bpe_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [bpe_pkg::ADC_BITS-1:0]      adc_sample,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bpe_pkg::PCT_W-1:0]         percent,
    output logic                              charging
);
    import bpe_pkg::*;

    cfg_t      cfg_reg;
    cfg_t      cfg_next;
    logic      front_valid;
    logic      front_ready;
    clamp_t    front_data;
    logic      seg_valid;
    logic      seg_ready;
    numer_t    seg_data;

    // The register file never pushes back; an index past the last register is dropped.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_BATTERY_MODEL:
                begin
                    cfg_next.battery_model = cfg_data[0];
                end
                REG_CHARGE_THRESHOLD:
                begin
                    cfg_next.charge_threshold_mv = cfg_data[MV_W-1:0];
                end
                REG_FULL_BATTERY:
                begin
                    cfg_next.full_battery_mv = cfg_data[MV_W-1:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.battery_model       <= MODEL_LIPO;
            cfg_reg.charge_threshold_mv <= MV_W'(4100);
            cfg_reg.full_battery_mv     <= MV_W'(NOMINAL_FULL_MV);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bpe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_sample (adc_sample),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    bpe_seg u_seg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (seg_valid),
        .out_ready (seg_ready),
        .out_data  (seg_data)
    );

    bpe_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (seg_valid),
        .in_ready  (seg_ready),
        .in_data   (seg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .percent   (percent),
        .charging  (charging)
    );

endmodule

// ----- test/battery_percent_estimator_test.sv -----
// Self-checking testbench for battery_percent_estimator: directed samples, then random phases.
// Depends on bpe_pkg for port widths and register indexes, and on the RTL under rtl/core.
// A built-in state-of-charge predictor and an in-order queue of expected results check every output.
module battery_percent_estimator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bpe_pkg::*;

    // Clock and run limits. The pipeline is six stages deep, so a short settle after
    // the last result is enough before touching a register or ending the run.
    localparam int HALF_PERIOD    = 5;
    localparam int SETTLE_CYCLES  = 12;
    localparam int SQUEEZE_CYCLES = 80;
    localparam int WATCHDOG_LIMIT = 1000;

    // Electrical constants of the estimator: 2x divider on a 3.3 V reference gives a
    // 6600 mV span over the ADC full scale. Voltages are kept exact in 1/FS mV units.
    localparam longint SAMPLE_FS = (longint'(1) << ADC_BITS) - 1;
    localparam longint ADC_SPAN_MV = 6600;
    localparam longint LOADED_FULL_MV = 3900;
    localparam longint CLAMP_FLOOR_MV = 3000;
    localparam longint CLAMP_CEIL_MV = 4200;
    localparam int LIPO_KNOTS = 13;

    localparam longint LIPO_KNOT_MV [LIPO_KNOTS] = '{
        3900, 3800, 3720, 3650, 3590, 3530, 3480,
        3440, 3400, 3360, 3300, 3150, 3000
    };
    localparam longint LIPO_KNOT_PCT [LIPO_KNOTS] = '{
        100, 90, 80, 70, 60, 50, 40, 30, 20, 15, 10, 5, 0
    };

    // Index 3 is past the end of the register list; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [PCT_W-1:0] percent;
        logic             charging;
    } soc_t;

    // One transaction that is offered: its sample and, where it is obvious, the answer.
    typedef struct packed {
        logic [ADC_BITS-1:0] sample;
        logic                known;
        soc_t                want;
    } probe_t;

    // Expectation typed into the directed table, paired with each offered sample in order.
    typedef struct packed {
        logic known;
        soc_t want;
    } typed_soc_t;

    typedef struct packed {
        logic model;
        int   threshold_mv;
        int   full_mv;
        int   count;
        int   tx_idle;
        int   rx_idle;
        logic poke_spare;
        logic squeeze;
    } phase_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [ADC_BITS-1:0]  adc_sample = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [PCT_W-1:0]     percent;
    logic                 charging;

    battery_percent_estimator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .adc_sample (adc_sample),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .percent    (percent),
        .charging   (charging)
    );

    always #HALF_PERIOD clk = ~clk;

    // Scoreboard state. The register shadow follows the configuration channel and starts
    // at the reset values of the block.
    soc_t       pending_soc [$];
    typed_soc_t typed_soc [$];
    logic       shadow_model = MODEL_LIPO;
    logic [MV_W-1:0] shadow_threshold_mv = 13'd4100;
    logic [MV_W-1:0] shadow_full_mv = 13'd3900;
    int         mismatch_count = 0;
    int         quiet_cycles = 0;

    // Idling controls. The sender percentage is used only by the stimulus process; the
    // receiver percentage and the squeeze request are handed over with nonblocking writes.
    int         tx_idle_pct = 35;
    int         rx_idle_pct = 71;
    logic       squeeze_req = 1'b0;
    logic       squeeze_seen = 1'b0;
    int         squeeze_left = 0;

    // Directed samples, all under reset settings (LiPo curve, 4100 mV threshold, no
    // load offset). Only the two ends of the ADC range carry a typed answer: an empty
    // battery reads 0 percent and a full-scale reading flags charging at 100 percent.
    // The rest sit on both sides of the charge threshold and of the lower clamp limit and
    // next to every curve knot, and go to the predictor.
    probe_t probes [24] = '{
        '{12'd0,    1'b1, '{8'd0,   1'b0}},
        '{12'd4095, 1'b1, '{8'd100, 1'b1}},
        '{12'd1,    1'b0, '{8'd0,   1'b0}},
        '{12'd2544, 1'b0, '{8'd0,   1'b0}},
        '{12'd2543, 1'b0, '{8'd0,   1'b0}},
        '{12'd1861, 1'b0, '{8'd0,   1'b0}},
        '{12'd1862, 1'b0, '{8'd0,   1'b0}},
        '{12'd1954, 1'b0, '{8'd0,   1'b0}},
        '{12'd1955, 1'b0, '{8'd0,   1'b0}},
        '{12'd2048, 1'b0, '{8'd0,   1'b0}},
        '{12'd2085, 1'b0, '{8'd0,   1'b0}},
        '{12'd2110, 1'b0, '{8'd0,   1'b0}},
        '{12'd2134, 1'b0, '{8'd0,   1'b0}},
        '{12'd2159, 1'b0, '{8'd0,   1'b0}},
        '{12'd2190, 1'b0, '{8'd0,   1'b0}},
        '{12'd2227, 1'b0, '{8'd0,   1'b0}},
        '{12'd2265, 1'b0, '{8'd0,   1'b0}},
        '{12'd2308, 1'b0, '{8'd0,   1'b0}},
        '{12'd2357, 1'b0, '{8'd0,   1'b0}},
        '{12'd2358, 1'b0, '{8'd0,   1'b0}},
        '{12'd2419, 1'b0, '{8'd0,   1'b0}},
        '{12'd2420, 1'b0, '{8'd0,   1'b0}},
        '{12'hAAA,  1'b0, '{8'd0,   1'b0}},
        '{12'h555,  1'b0, '{8'd0,   1'b0}}
    };

    // Random phases. The first two run with a slow receiver, the next two with a slow
    // sender, and the rest with no idling at all. Between them the settings sweep both
    // models, a threshold of zero (every sample charges), a threshold exactly at full
    // scale, one that can never be reached, and load offsets from strongly positive
    // (at or near the top clamp) to strongly negative (pinned at the bottom clamp).
    phase_t plan [8] = '{
        '{MODEL_LIPO,   4100, 3900, 90, 35, 71, 1'b0, 1'b0},
        '{MODEL_LINEAR, 6600, 4500, 70, 35, 71, 1'b0, 1'b0},
        '{MODEL_LINEAR, 4100, 3900, 90, 71, 35, 1'b0, 1'b0},
        '{MODEL_LIPO,   8191, 0,    50, 71, 35, 1'b0, 1'b0},
        '{MODEL_LIPO,   0,    3000, 40, 0,  0,  1'b0, 1'b0},
        '{MODEL_LINEAR, 8191, 8191, 40, 0,  0,  1'b1, 1'b0},
        '{MODEL_LIPO,   6600, 3000, 90, 0,  0,  1'b0, 1'b1},
        '{MODEL_LINEAR, 4350, 3650, 80, 0,  0,  1'b0, 1'b0}
    };

    // State-of-charge prediction. The sample becomes an exact voltage in 1/FS mV; the
    // charge test, the clamp and the segment search are integer comparisons, and the
    // percentage is the floor of an exact quotient, which is never negative.
    function automatic soc_t estimate_soc(input logic [ADC_BITS-1:0] sample,
                                          input logic model,
                                          input logic [MV_W-1:0] threshold_mv,
                                          input logic [MV_W-1:0] full_mv);
        longint raw;
        longint volts;
        longint knot_lo;
        longint pct;
        logic   found;
        soc_t   soc;
        begin
            raw = longint'(sample) * ADC_SPAN_MV;
            soc.charging = 1'b0;
            pct = 0;
            if (raw >= longint'(threshold_mv) * SAMPLE_FS)
            begin
                soc.charging = 1'b1;
                pct = 100;
            end
            else
            begin
                volts = raw + (LOADED_FULL_MV - longint'(full_mv)) * SAMPLE_FS;
                if (volts < CLAMP_FLOOR_MV * SAMPLE_FS)
                begin
                    volts = CLAMP_FLOOR_MV * SAMPLE_FS;
                end
                if (volts > CLAMP_CEIL_MV * SAMPLE_FS)
                begin
                    volts = CLAMP_CEIL_MV * SAMPLE_FS;
                end
                if (model == MODEL_LINEAR)
                begin
                    pct = ((volts - CLAMP_FLOOR_MV * SAMPLE_FS) * 100) /
                          ((CLAMP_CEIL_MV - CLAMP_FLOOR_MV) * SAMPLE_FS);
                end
                else
                begin
                    // The top segment has no upper bound here, which is what lets
                    // voltages above 3.9 V run past 100 percent.
                    found = 1'b0;
                    for (int k = 0; k < LIPO_KNOTS - 1; k++)
                    begin
                        knot_lo = LIPO_KNOT_MV[k + 1] * SAMPLE_FS;
                        if (!found && volts >= knot_lo)
                        begin
                            found = 1'b1;
                            pct = LIPO_KNOT_PCT[k + 1] +
                                  ((volts - knot_lo) * (LIPO_KNOT_PCT[k] - LIPO_KNOT_PCT[k + 1])) /
                                  ((LIPO_KNOT_MV[k] - LIPO_KNOT_MV[k + 1]) * SAMPLE_FS);
                        end
                    end
                end
            end
            soc.percent = PCT_W'(pct);
            return soc;
        end
    endfunction

    // Random sample for a phase. Most samples aim at the clamp window after the load
    // offset, where the curve does its work; some hug the charge threshold, the rest
    // spread over the whole ADC range, with the two ends hit now and then.
    function automatic logic [ADC_BITS-1:0] pick_sample(input int threshold_mv,
                                                        input int full_mv);
        int pick;
        int target_mv;
        int sample;
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
            begin
                sample = (pick == 0) ? 0 : int'(SAMPLE_FS);
            end
            else if (pick < 30)
            begin
                sample = $urandom_range(0, int'(SAMPLE_FS));
            end
            else if (pick < 45)
            begin
                sample = (threshold_mv * int'(SAMPLE_FS) + int'(ADC_SPAN_MV) - 1) /
                         int'(ADC_SPAN_MV) + int'($urandom_range(0, 8)) - 4;
            end
            else
            begin
                target_mv = int'($urandom_range(2950, 4250)) -
                            (int'(LOADED_FULL_MV) - full_mv);
                sample = target_mv * int'(SAMPLE_FS) / int'(ADC_SPAN_MV);
            end
            if (sample < 0)
            begin
                sample = 0;
            end
            if (sample > int'(SAMPLE_FS))
            begin
                sample = int'(SAMPLE_FS);
            end
            return ADC_BITS'(sample);
        end
    endfunction

    task automatic flag_soc_error(input string what, input int got, input int want);
        begin
            mismatch_count++;
            $display("%0t ns: %s is %0d, predicted %0d", $time, what, got, want);
        end
    endtask

    // Offers one sample and holds it until the transaction completes. After the
    // transaction the sender may idle at random; while idle the sample bus
    // carries noise that must be ignored. Valid is lowered only when an idle cycle
    // follows, so a back-to-back transaction never sees valid dropped and raised in
    // the same time step.
    task automatic offer_sample(input logic [ADC_BITS-1:0] sample, input logic known,
                                input soc_t want);
        begin
            typed_soc.push_back('{known, want});
            in_valid <= 1'b1;
            adc_sample <= sample;
            do @(posedge clk); while (!in_ready);
            while (int'($urandom_range(0, 99)) < tx_idle_pct)
            begin
                in_valid <= 1'b0;
                adc_sample <= ADC_BITS'($urandom);
                @(posedge clk);
            end
        end
    endtask

    // Writes all three registers of a phase, back to back, and optionally pokes the
    // spare index. The model bit goes out with random upper bits, which the block must
    // mask off.
    task automatic write_settings(input phase_t ph);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [CFG_W-1:0]     val [4];
        int                   writes;
        begin
            idx[0] = REG_BATTERY_MODEL;
            val[0] = (CFG_W'($urandom) & ~CFG_W'(1)) | CFG_W'(ph.model);
            idx[1] = REG_CHARGE_THRESHOLD;
            val[1] = CFG_W'(ph.threshold_mv);
            idx[2] = REG_FULL_BATTERY;
            val[2] = CFG_W'(ph.full_mv);
            idx[3] = REG_SPARE;
            val[3] = CFG_W'($urandom);
            writes = ph.poke_spare ? 4 : 3;
            for (int k = 0; k < writes; k++)
            begin
                cfg_valid <= 1'b1;
                cfg_index <= idx[k];
                cfg_data <= val[k];
                do @(posedge clk); while (!cfg_ready);
            end
            cfg_valid <= 1'b0;
        end
    endtask

    // Waits until every expected result has come back, then lets the pipeline run dry.
    task automatic drain_results();
        begin
            while (pending_soc.size() != 0)
            begin
                @(posedge clk);
            end
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    // Receiver. Each cycle it stalls with the phase's probability, except during a
    // squeeze: a long stretch with out_ready low, counted here, that lets the pipeline
    // fill and push back on the sender.
    always @(posedge clk)
    begin
        if (squeeze_req != squeeze_seen)
        begin
            squeeze_seen <= squeeze_req;
            squeeze_left <= SQUEEZE_CYCLES;
            out_ready <= 1'b0;
        end
        else if (squeeze_left > 0)
        begin
            squeeze_left <= squeeze_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= (int'($urandom_range(0, 99)) >= rx_idle_pct);
        end
    end

    // Scoreboard. Everything is sampled at the rising edge, before any of this edge's
    // updates land, so the view is the same whatever order the processes run in. A
    // register write updates the shadow, an accepted sample queues its expected
    // result, and an accepted result is checked against the oldest one in the queue.
    always @(posedge clk)
    begin : scoreboard
        typed_soc_t typed;
        soc_t       want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_BATTERY_MODEL:    shadow_model = cfg_data[0];
                    REG_CHARGE_THRESHOLD: shadow_threshold_mv = cfg_data[MV_W-1:0];
                    REG_FULL_BATTERY:     shadow_full_mv = cfg_data[MV_W-1:0];
                    default:              ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                want = estimate_soc(adc_sample, shadow_model, shadow_threshold_mv,
                                    shadow_full_mv);
                if (typed_soc.size() != 0)
                begin
                    typed = typed_soc.pop_front();
                    if (typed.known)
                    begin
                        want = typed.want;
                    end
                end
                pending_soc.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                if (pending_soc.size() == 0)
                begin
                    flag_soc_error("unrequested result, percent", int'(percent), -1);
                end
                else
                begin
                    want = pending_soc.pop_front();
                    if (percent !== want.percent)
                    begin
                        flag_soc_error("percent", int'(percent), int'(want.percent));
                    end
                    if (charging !== want.charging)
                    begin
                        flag_soc_error("charging", int'(charging), int'(want.charging));
                    end
                end
            end
            if ((cfg_valid && cfg_ready) || (in_valid && in_ready) ||
                (out_valid && out_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
    end

    // Watchdog: a stretch with no transaction on any channel means the block hangs.
    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Stimulus: reset, the directed table under reset settings, then the random phases.
    initial
    begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < $size(probes); k++)
        begin
            offer_sample(probes[k].sample, probes[k].known, probes[k].want);
        end
        in_valid <= 1'b0;
        drain_results();

        for (int p = 0; p < $size(plan); p++)
        begin
            write_settings(plan[p]);
            tx_idle_pct = plan[p].tx_idle;
            rx_idle_pct <= plan[p].rx_idle;
            for (int k = 0; k < plan[p].count; k++)
            begin
                // Start the squeeze a little way into the phase, with the sender
                // still offering every cycle.
                if (plan[p].squeeze && k == 12)
                begin
                    squeeze_req <= ~squeeze_req;
                end
                offer_sample(pick_sample(plan[p].threshold_mv, plan[p].full_mv),
                             1'b0, '0);
            end
            in_valid <= 1'b0;
            drain_results();
        end

        if (mismatch_count == 0 && pending_soc.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- battery_percent_estimator.f -----
rtl/core/bpe_pkg.sv
rtl/core/bpe_front.sv
rtl/core/bpe_seg.sv
rtl/core/bpe_div.sv
rtl/core/battery_percent_estimator.sv
test/battery_percent_estimator_test.sv
